>>> rtl/vwbp_pkg.sv
// ----------------------------------------------------------------------------
// vwbp_pkg
// Shared types and constants of the variable-width bit packer.
// ----------------------------------------------------------------------------
package vwbp_pkg;

  localparam int STORE_BITS_DEF     = 4096;
  localparam int MAX_FIELD_BITS_DEF = 32;
  localparam int DATA_W             = 32;
  localparam int FWIDTH_W           = 6;
  localparam int CNT_OUT_W          = 13;
  localparam int WORD_W             = 32;
  localparam int OFF_W              = 5;

  typedef enum logic [2:0] {
    FUNC_APPEND_U = 3'd0,
    FUNC_APPEND_S = 3'd1,
    FUNC_READ_U   = 3'd2,
    FUNC_READ_S   = 3'd3,
    FUNC_RESTART  = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RANGE     = 3'd1,
    ST_FULL      = 3'd2,
    ST_PAST_END  = 3'd3,
    ST_BAD_WIDTH = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    KIND_APPEND,
    KIND_READ,
    KIND_RESTART,
    KIND_NOP
  } kind_e;

  typedef enum logic {
    BK_IDLE,
    BK_MEM
  } back_state_e;

  typedef struct packed {
    kind_e                kind;
    logic                 is_signed;
    status_e              pre_status;
    logic [DATA_W-1:0]    data;
    logic [FWIDTH_W-1:0]  width;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0]    read_value;
    status_e              status;
    logic [CNT_OUT_W-1:0] bits_written;
    logic [CNT_OUT_W-1:0] read_position;
  } res_t;

endpackage

>>> rtl/vwbp_front.sv
// ----------------------------------------------------------------------------
// vwbp_front
// Decodes an incoming command and performs the width and range checks that
// do not depend on the store state.
// ----------------------------------------------------------------------------
module vwbp_front #(
  parameter int MAX_FIELD_BITS = vwbp_pkg::MAX_FIELD_BITS_DEF
) (
  input  logic [2:0]                      func_i,
  input  logic [vwbp_pkg::DATA_W-1:0]     data_i,
  input  logic [vwbp_pkg::FWIDTH_W-1:0]   width_i,
  output vwbp_pkg::cmd_t                  cmd_o
);

  localparam int WidthLimit = (MAX_FIELD_BITS < 32) ? MAX_FIELD_BITS : 32;

  logic        width_ok;
  logic [63:0] mask_w;
  logic [63:0] mask_wm1;
  logic [31:0] upper;
  logic [31:0] hi;
  logic        u_range_bad;
  logic        s_range_bad;

  assign width_ok    = (width_i >= 6'd1) &&
                       (width_i <= vwbp_pkg::FWIDTH_W'(WidthLimit));
  assign mask_w      = (64'd1 << width_i) - 64'd1;
  assign mask_wm1    = (64'd1 << (width_i - 6'd1)) - 64'd1;
  assign upper       = ~mask_wm1[31:0];
  assign hi          = data_i & upper;
  assign u_range_bad = (data_i & ~mask_w[31:0]) != 32'd0;
  assign s_range_bad = (hi != 32'd0) && (hi != upper);

  always_comb begin
    cmd_o.data       = data_i;
    cmd_o.width      = width_i;
    cmd_o.is_signed  = 1'b0;
    cmd_o.pre_status = vwbp_pkg::ST_OK;
    cmd_o.kind       = vwbp_pkg::KIND_NOP;
    unique case (func_i)
      vwbp_pkg::FUNC_APPEND_U: begin
        cmd_o.kind = vwbp_pkg::KIND_APPEND;
        if (!width_ok) begin
          cmd_o.pre_status = vwbp_pkg::ST_BAD_WIDTH;
        end else if (u_range_bad) begin
          cmd_o.pre_status = vwbp_pkg::ST_RANGE;
        end
      end
      vwbp_pkg::FUNC_APPEND_S: begin
        cmd_o.kind      = vwbp_pkg::KIND_APPEND;
        cmd_o.is_signed = 1'b1;
        if (!width_ok || (width_i < 6'd2)) begin
          cmd_o.pre_status = vwbp_pkg::ST_BAD_WIDTH;
        end else if (s_range_bad) begin
          cmd_o.pre_status = vwbp_pkg::ST_RANGE;
        end
      end
      vwbp_pkg::FUNC_READ_U: begin
        cmd_o.kind = vwbp_pkg::KIND_READ;
        if (!width_ok) begin
          cmd_o.pre_status = vwbp_pkg::ST_BAD_WIDTH;
        end
      end
      vwbp_pkg::FUNC_READ_S: begin
        cmd_o.kind      = vwbp_pkg::KIND_READ;
        cmd_o.is_signed = 1'b1;
        if (!width_ok) begin
          cmd_o.pre_status = vwbp_pkg::ST_BAD_WIDTH;
        end
      end
      vwbp_pkg::FUNC_RESTART: begin
        cmd_o.kind = vwbp_pkg::KIND_RESTART;
      end
      default: begin
        cmd_o.kind = vwbp_pkg::KIND_NOP;
      end
    endcase
  end

endmodule

>>> rtl/vwbp_fifo.sv
// ----------------------------------------------------------------------------
// vwbp_fifo
// Two-entry command queue between the decode stage and the store engine.
// ----------------------------------------------------------------------------
module vwbp_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  vwbp_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output vwbp_pkg::cmd_t head_o,
  output logic           empty_o
);

  vwbp_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           do_push;
  logic           do_pop;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/vwbp_back.sv
// ----------------------------------------------------------------------------
// vwbp_back
// Store engine: keeps the write and read counters, checks room and end of
// data, and moves fields through two banks of 32-bit words.
// ----------------------------------------------------------------------------
module vwbp_back #(
  parameter int STORE_BITS = vwbp_pkg::STORE_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  vwbp_pkg::cmd_t cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output vwbp_pkg::res_t res_o
);

  localparam int CW        = $clog2(STORE_BITS + 1);
  localparam int KW        = CW - vwbp_pkg::OFF_W;
  localparam int Words     = (STORE_BITS + vwbp_pkg::WORD_W - 1) / vwbp_pkg::WORD_W;
  localparam int BankDepth = Words / 2 + 1;
  localparam int AW        = (BankDepth > 1) ? $clog2(BankDepth) : 1;
  localparam int EW        = (CW > vwbp_pkg::CNT_OUT_W) ? CW : vwbp_pkg::CNT_OUT_W;

  logic [vwbp_pkg::WORD_W-1:0] bank0 [BankDepth];
  logic [vwbp_pkg::WORD_W-1:0] bank1 [BankDepth];
  logic [vwbp_pkg::WORD_W-1:0] rd0_q, rd1_q;

  vwbp_pkg::back_state_e       state_q, state_d;
  logic [CW-1:0]               wc_q, wc_d;
  logic [CW-1:0]               rp_q, rp_d;
  logic                        ov_q, ov_d;
  vwbp_pkg::res_t              res_q, res_d;

  vwbp_pkg::kind_e             kind_q, kind_d;
  logic                        sgn_q, sgn_d;
  logic [vwbp_pkg::DATA_W-1:0] data_q, data_d;
  logic [vwbp_pkg::FWIDTH_W-1:0] width_q, width_d;
  logic [vwbp_pkg::OFF_W-1:0]  off_q, off_d;
  logic                        odd_q, odd_d;
  logic [AW-1:0]               a0_q, a0_d;
  logic [AW-1:0]               a1_q, a1_d;

  logic                        mem_re;
  logic                        mem_we;
  logic [CW-1:0]               pos;
  logic [KW-1:0]               word_idx;
  logic [KW-2:0]               half;
  logic [CW:0]                 sum_wc;
  logic [CW:0]                 sum_rp;
  logic [63:0]                 lm64;
  logic [63:0]                 pair;
  logic [63:0]                 new_pair;
  logic [31:0]                 rd_val;
  logic [4:0]                  msb_idx;
  logic [31:0]                 wdata0;
  logic [31:0]                 wdata1;
  logic [EW-1:0]               wc_ext;
  logic [EW-1:0]               rp_ext;

  assign word_idx = pos[CW-1:vwbp_pkg::OFF_W];
  assign half     = word_idx[KW-1:1];
  assign sum_wc   = {1'b0, wc_q} + (CW+1)'(cmd_i.width);
  assign sum_rp   = {1'b0, rp_q} + (CW+1)'(cmd_i.width);
  assign lm64     = (64'd1 << width_q) - 64'd1;
  assign pair     = odd_q ? {rd0_q, rd1_q} : {rd1_q, rd0_q};
  assign new_pair = (pair & ~(lm64 << off_q)) | (((64'(data_q)) & lm64) << off_q);
  assign wdata0   = odd_q ? new_pair[63:32] : new_pair[31:0];
  assign wdata1   = odd_q ? new_pair[31:0] : new_pair[63:32];
  assign msb_idx  = 5'(width_q - 6'd1);
  assign wc_ext   = EW'(wc_d);
  assign rp_ext   = EW'(rp_d);

  always_comb begin
    rd_val = 32'((pair >> off_q) & lm64);
    if (sgn_q && (width_q < 6'd32) && rd_val[msb_idx]) begin
      rd_val = rd_val | ~lm64[31:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    wc_d      = wc_q;
    rp_d      = rp_q;
    ov_d      = ov_q && !res_ready_i;
    res_d     = res_q;
    kind_d    = kind_q;
    sgn_d     = sgn_q;
    data_d    = data_q;
    width_d   = width_q;
    off_d     = off_q;
    odd_d     = odd_q;
    a0_d      = a0_q;
    a1_d      = a1_q;
    cmd_pop_o = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    pos       = wc_q;
    res_d.read_value = res_q.read_value;
    unique case (state_q)
      vwbp_pkg::BK_IDLE: begin
        if (cmd_i.kind == vwbp_pkg::KIND_READ) begin
          pos = rp_q;
        end
        if (!cmd_empty_i && (!ov_q || res_ready_i)) begin
          cmd_pop_o = 1'b1;
          kind_d    = cmd_i.kind;
          sgn_d     = cmd_i.is_signed;
          data_d    = cmd_i.data;
          width_d   = cmd_i.width;
          off_d     = pos[vwbp_pkg::OFF_W-1:0];
          odd_d     = word_idx[0];
          a0_d      = word_idx[0] ? AW'(half + 1'b1) : AW'(half);
          a1_d      = AW'(half);
          res_d.read_value = '0;
          res_d.status     = vwbp_pkg::ST_OK;
          ov_d             = 1'b1;
          unique case (cmd_i.kind)
            vwbp_pkg::KIND_APPEND: begin
              if (cmd_i.pre_status != vwbp_pkg::ST_OK) begin
                res_d.status = cmd_i.pre_status;
              end else if (sum_wc > (CW+1)'(STORE_BITS)) begin
                res_d.status = vwbp_pkg::ST_FULL;
              end else begin
                ov_d    = 1'b0;
                mem_re  = 1'b1;
                state_d = vwbp_pkg::BK_MEM;
              end
            end
            vwbp_pkg::KIND_READ: begin
              if (cmd_i.pre_status != vwbp_pkg::ST_OK) begin
                res_d.status = cmd_i.pre_status;
              end else if (sum_rp > {1'b0, wc_q}) begin
                res_d.status = vwbp_pkg::ST_PAST_END;
              end else begin
                ov_d    = 1'b0;
                mem_re  = 1'b1;
                state_d = vwbp_pkg::BK_MEM;
              end
            end
            vwbp_pkg::KIND_RESTART: begin
              rp_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      vwbp_pkg::BK_MEM: begin
        state_d      = vwbp_pkg::BK_IDLE;
        ov_d         = 1'b1;
        res_d.status = vwbp_pkg::ST_OK;
        if (kind_q == vwbp_pkg::KIND_APPEND) begin
          mem_we           = 1'b1;
          wc_d             = wc_q + CW'(width_q);
          res_d.read_value = '0;
        end else begin
          rp_d             = rp_q + CW'(width_q);
          res_d.read_value = rd_val;
        end
      end
      default: begin
        state_d = vwbp_pkg::BK_IDLE;
      end
    endcase
    res_d.bits_written  = wc_ext[vwbp_pkg::CNT_OUT_W-1:0];
    res_d.read_position = rp_ext[vwbp_pkg::CNT_OUT_W-1:0];
    if (!(ov_d && !(ov_q && !res_ready_i))) begin
      res_d = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vwbp_pkg::BK_IDLE;
      wc_q    <= '0;
      rp_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      wc_q    <= wc_d;
      rp_q    <= rp_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    kind_q  <= kind_d;
    sgn_q   <= sgn_d;
    data_q  <= data_d;
    width_q <= width_d;
    off_q   <= off_d;
    odd_q   <= odd_d;
    a0_q    <= a0_d;
    a1_q    <= a1_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd0_q <= bank0[a0_d];
      rd1_q <= bank1[a1_d];
    end
    if (mem_we) begin
      bank0[a0_q] <= wdata0;
      bank1[a1_q] <= wdata1;
    end
  end

  assign res_valid_o = ov_q;
  assign res_o       = res_q;

endmodule

>>> rtl/variable_width_bit_packer_core.sv
// ----------------------------------------------------------------------------
// variable_width_bit_packer_core
// LSB-first packer and unpacker of 1 to 32 bit fields in an on-chip store.
// ----------------------------------------------------------------------------
// The slave stream carries one command per transaction: tuser holds the
// function code, tdata the value and the field width. The master stream
// returns exactly one result per command, in order: tuser holds the status,
// tdata the value read and both bit counters after the command.
// A decode stage checks width and range and writes into a two-entry queue;
// the store engine behind it checks room and end of data and accesses the
// store. A restart, an unused code or any refused command is finished in
// the engine's idle state; a successful append or read also passes through
// the memory state: the idle state reads two adjacent 32-bit words from the
// even and odd banks, and the memory state merges and writes back or
// extracts. The result is registered as the engine finishes each command.
// Reset clears both counters at once; a read only ever returns bits below
// the write count, so the store itself needs no clearing pass. When the
// receiver stalls, the result register holds, the engine stops and the
// queue fills, after which s_axis_tready_o drops.
// ----------------------------------------------------------------------------
module variable_width_bit_packer_core #(
  parameter int STORE_BITS     = vwbp_pkg::STORE_BITS_DEF,
  parameter int MAX_FIELD_BITS = vwbp_pkg::MAX_FIELD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // data_in[31:0], field_width[37:32], zero pad
  input  logic [2:0]  s_axis_tuser_i,   // func[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // read_value[31:0], bits_written[44:32],
                                        // read_position[57:45], zero pad
  output logic [2:0]  m_axis_tuser_o    // status[2:0]
);

  vwbp_pkg::cmd_t front_cmd;
  vwbp_pkg::cmd_t head_cmd;
  vwbp_pkg::res_t res;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  vwbp_front #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS)
  ) u_front (
    .func_i (s_axis_tuser_i),
    .data_i (s_axis_tdata_i[31:0]),
    .width_i(s_axis_tdata_i[37:32]),
    .cmd_o  (front_cmd)
  );

  vwbp_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s_axis_tvalid_i),
    .push_data_i(front_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .head_o     (head_cmd),
    .empty_o    (q_empty)
  );

  vwbp_back #(
    .STORE_BITS(STORE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (head_cmd),
    .cmd_empty_i(q_empty),
    .cmd_pop_o  (q_pop),
    .res_valid_o(m_axis_tvalid_o),
    .res_ready_i(m_axis_tready_i),
    .res_o      (res)
  );

  assign s_axis_tready_o = !q_full;
  assign m_axis_tdata_o  = {6'd0, res.read_position, res.bits_written, res.read_value};
  assign m_axis_tuser_o  = res.status;

endmodule
